[sv/cp_pkg.sv]
// Shared types, widths and codes for the collinearity projection block.
package cp_pkg;

    localparam int COORD_W = 32;
    localparam int ROT_W   = 16;
    localparam int FOC_W   = 24;
    localparam int PP_W    = 24;

    localparam int REG_N   = 8;
    localparam int DATA_W  = 64;
    localparam int ADDR_W  = $clog2(REG_N) + 3;

    // datapath widths
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = ROT_W + DIFF_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int MAG_A_W = DIFF_W;
    localparam int MAG_N_W = SUM_W;
    localparam int NLO_W   = MAG_N_W / 2;
    localparam int NHI_W   = MAG_N_W - NLO_W;
    localparam int P_W     = MAG_A_W + MAG_N_W;
    localparam int QB      = COORD_W + 3;
    localparam int TOP_W   = P_W - QB;
    localparam int CMP_W   = (TOP_W > MAG_N_W) ? TOP_W : MAG_N_W;
    localparam int FIN_W   = QB + 2;

    // pipeline depth
    localparam int FRONT_LAT = 3;
    localparam int MD_LAT    = 4 + QB;
    localparam int TOT_LAT   = FRONT_LAT + MD_LAT + 1;

    typedef enum logic [2:0] {
        REG_ROT1, REG_ROT2, REG_ROT3, REG_CX, REG_CY, REG_CZ, REG_FOC, REG_PP
    } t_reg_idx;

    typedef enum logic {
        OP_PROJECT   = 1'b0,
        OP_INTERSECT = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_SAT  = 2'd2
    } t_status;

    typedef struct packed {
        logic [3*ROT_W-1:0]         rot1;
        logic [3*ROT_W-1:0]         rot2;
        logic [3*ROT_W-1:0]         rot3;
        logic signed [COORD_W-1:0]  cx;
        logic signed [COORD_W-1:0]  cy;
        logic signed [COORD_W-1:0]  cz;
        logic [FOC_W-1:0]           foc;
        logic [2*PP_W-1:0]          pp;
    } t_cfg;

    typedef struct packed {
        t_op                        op;
        logic signed [COORD_W-1:0]  z;
        logic signed [DIFF_W-1:0]   dz;
        logic signed [SUM_W-1:0]    n1;
        logic signed [SUM_W-1:0]    n2;
        logic signed [SUM_W-1:0]    d;
    } t_front;

    typedef struct packed {
        t_op                        op;
        logic                       zero;
        logic [COORD_W-1:0]         z;
    } t_side;

    function automatic logic signed [ROT_W-1:0] rot_entry(input logic [3*ROT_W-1:0] row,
                                                          input int k);
        return row[k*ROT_W +: ROT_W];
    endfunction

endpackage

[sv/cp_regs.sv]
// Configuration register file behind the APB port.
module cp_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cp_pkg::ADDR_W-1:0]   paddr,
    input  logic [cp_pkg::DATA_W-1:0]   pwdata,
    output logic [cp_pkg::DATA_W-1:0]   prdata,
    output logic                        pready,
    output cp_pkg::t_cfg                o_cfg
);
    import cp_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:3]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rot1 <= '0;
            r_cfg.rot2 <= '0;
            r_cfg.rot3 <= '0;
            r_cfg.cx   <= '0;
            r_cfg.cy   <= '0;
            r_cfg.cz   <= '0;
            r_cfg.foc  <= FOC_W'(1);
            r_cfg.pp   <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_ROT1: r_cfg.rot1 <= pwdata[3*ROT_W-1:0];
                REG_ROT2: r_cfg.rot2 <= pwdata[3*ROT_W-1:0];
                REG_ROT3: r_cfg.rot3 <= pwdata[3*ROT_W-1:0];
                REG_CX:   r_cfg.cx   <= pwdata[COORD_W-1:0];
                REG_CY:   r_cfg.cy   <= pwdata[COORD_W-1:0];
                REG_CZ:   r_cfg.cz   <= pwdata[COORD_W-1:0];
                REG_FOC:  r_cfg.foc  <= pwdata[FOC_W-1:0];
                REG_PP:   r_cfg.pp   <= pwdata[2*PP_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_ROT1: prdata = DATA_W'(r_cfg.rot1);
            REG_ROT2: prdata = DATA_W'(r_cfg.rot2);
            REG_ROT3: prdata = DATA_W'(r_cfg.rot3);
            REG_CX:   prdata = DATA_W'($unsigned(r_cfg.cx));
            REG_CY:   prdata = DATA_W'($unsigned(r_cfg.cy));
            REG_CZ:   prdata = DATA_W'($unsigned(r_cfg.cz));
            REG_FOC:  prdata = DATA_W'(r_cfg.foc);
            REG_PP:   prdata = DATA_W'(r_cfg.pp);
        endcase
    end

endmodule

[sv/cp_front.sv]
// Front end: coordinate differences, rotation products and the three dot products.
module cp_front (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic                                i_op,
    input  logic signed [cp_pkg::COORD_W-1:0]   i_a,
    input  logic signed [cp_pkg::COORD_W-1:0]   i_b,
    input  logic signed [cp_pkg::COORD_W-1:0]   i_z,
    input  cp_pkg::t_cfg                        i_cfg,
    output cp_pkg::t_front                      o_front
);
    import cp_pkg::*;

    logic [3*ROT_W-1:0]         w_row [3];
    logic signed [ROT_W-1:0]    w_r   [3][3];
    logic signed [ROT_W-1:0]    w_c   [3][3];
    logic signed [DIFF_W-1:0]   w_e   [3];
    logic signed [DIFF_W-1:0]   w_dz;
    logic signed [PP_W-1:0]     w_p0;
    logic signed [PP_W-1:0]     w_q0;

    // stage 1
    t_op                        r1_op;
    logic signed [COORD_W-1:0]  r1_z;
    logic signed [DIFF_W-1:0]   r1_dz;
    logic signed [DIFF_W-1:0]   r1_e [3];
    logic signed [ROT_W-1:0]    r1_c [3][3];
    // stage 2
    t_op                        r2_op;
    logic signed [COORD_W-1:0]  r2_z;
    logic signed [DIFF_W-1:0]   r2_dz;
    logic signed [PROD_W-1:0]   r2_p [3][3];
    // stage 3
    t_front                     r3_front;

    assign w_row[0] = i_cfg.rot1;
    assign w_row[1] = i_cfg.rot2;
    assign w_row[2] = i_cfg.rot3;
    assign w_p0     = i_cfg.pp[PP_W-1:0];
    assign w_q0     = i_cfg.pp[2*PP_W-1:PP_W];
    assign w_dz     = DIFF_W'(i_z) - DIFF_W'(i_cfg.cz);

    // projection uses the transposed matrix, intersection the rows
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                w_r[i][j] = rot_entry(w_row[i], j);
            end
        end
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                w_c[k][j] = (i_op == OP_PROJECT) ? w_r[j][k] : w_r[k][j];
            end
        end
        if (i_op == OP_PROJECT) begin
            w_e[0] = DIFF_W'(i_a) - DIFF_W'(i_cfg.cx);
            w_e[1] = DIFF_W'(i_b) - DIFF_W'(i_cfg.cy);
            w_e[2] = w_dz;
        end else begin
            w_e[0] = DIFF_W'(i_a) - DIFF_W'(w_p0);
            w_e[1] = DIFF_W'(i_b) - DIFF_W'(w_q0);
            w_e[2] = -$signed(DIFF_W'(i_cfg.foc));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_op <= t_op'(i_op);
            r1_z  <= i_z;
            r1_dz <= w_dz;
            for (int k = 0; k < 3; k++) begin
                r1_e[k] <= w_e[k];
                for (int j = 0; j < 3; j++) begin
                    r1_c[k][j] <= w_c[k][j];
                end
            end

            r2_op <= r1_op;
            r2_z  <= r1_z;
            r2_dz <= r1_dz;
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r2_p[k][j] <= PROD_W'(r1_c[k][j]) * PROD_W'(r1_e[j]);
                end
            end

            r3_front.op <= r2_op;
            r3_front.z  <= r2_z;
            r3_front.dz <= r2_dz;
            r3_front.n1 <= SUM_W'(r2_p[0][0]) + SUM_W'(r2_p[0][1]) + SUM_W'(r2_p[0][2]);
            r3_front.n2 <= SUM_W'(r2_p[1][0]) + SUM_W'(r2_p[1][1]) + SUM_W'(r2_p[1][2]);
            r3_front.d  <= SUM_W'(r2_p[2][0]) + SUM_W'(r2_p[2][1]) + SUM_W'(r2_p[2][2]);
        end
    end

    assign o_front = r3_front;

endmodule

[sv/cp_muldiv.sv]
// Pipelined trunc(a*n/d): split multiply, then one restoring quotient bit per stage.
module cp_muldiv (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [cp_pkg::MAG_A_W-1:0]   i_a,
    input  logic signed [cp_pkg::SUM_W-1:0]     i_n,
    input  logic signed [cp_pkg::SUM_W-1:0]     i_d,
    output logic [cp_pkg::QB-1:0]               o_q,
    output logic                                o_ovf,
    output logic                                o_neg
);
    import cp_pkg::*;

    logic [TOP_W-1:0]           w_top;
    logic [MAG_N_W:0]           w_t    [QB];
    logic [MAG_N_W:0]           w_diff [QB];
    logic                       w_ge   [QB];

    logic [MAG_A_W-1:0]         r1_am;
    logic [MAG_N_W-1:0]         r1_nm;
    logic [MAG_N_W-1:0]         r1_dm;
    logic                       r1_neg;
    logic [MAG_A_W+NLO_W-1:0]   r2_pl;
    logic [MAG_A_W+NHI_W-1:0]   r2_ph;
    logic [MAG_N_W-1:0]         r2_dm;
    logic                       r2_neg;
    logic [P_W-1:0]             r3_p;
    logic [MAG_N_W-1:0]         r3_dm;
    logic                       r3_neg;

    logic [MAG_N_W-1:0]         r_rem [0:QB];
    logic [QB-1:0]              r_low [0:QB];
    logic [QB-1:0]              r_q   [0:QB];
    logic [MAG_N_W-1:0]         r_dm  [0:QB];
    logic                       r_neg [0:QB];
    logic                       r_ovf [0:QB];

    assign w_top = r3_p[P_W-1:QB];

    always_comb begin
        for (int k = 0; k < QB; k++) begin
            w_t[k]    = {r_rem[k], r_low[k][QB-1]};
            w_ge[k]   = w_t[k] >= {1'b0, r_dm[k]};
            w_diff[k] = w_t[k] - {1'b0, r_dm[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_am  <= MAG_A_W'(i_a[MAG_A_W-1] ? -i_a : i_a);
            r1_nm  <= MAG_N_W'(i_n[SUM_W-1] ? -i_n : i_n);
            r1_dm  <= MAG_N_W'(i_d[SUM_W-1] ? -i_d : i_d);
            r1_neg <= i_a[MAG_A_W-1] ^ i_n[SUM_W-1] ^ i_d[SUM_W-1];

            r2_pl  <= (MAG_A_W+NLO_W)'(r1_am) * (MAG_A_W+NLO_W)'(r1_nm[NLO_W-1:0]);
            r2_ph  <= (MAG_A_W+NHI_W)'(r1_am) * (MAG_A_W+NHI_W)'(r1_nm[MAG_N_W-1:NLO_W]);
            r2_dm  <= r1_dm;
            r2_neg <= r1_neg;

            r3_p   <= P_W'(r2_pl) + (P_W'(r2_ph) << NLO_W);
            r3_dm  <= r2_dm;
            r3_neg <= r2_neg;

            // quotient at or above 2^QB always clamps; flag it up front
            r_rem[0] <= MAG_N_W'(w_top);
            r_low[0] <= r3_p[QB-1:0];
            r_q[0]   <= '0;
            r_dm[0]  <= r3_dm;
            r_neg[0] <= r3_neg;
            r_ovf[0] <= CMP_W'(w_top) >= CMP_W'(r3_dm);

            for (int k = 0; k < QB; k++) begin
                r_rem[k+1] <= w_ge[k] ? w_diff[k][MAG_N_W-1:0] : w_t[k][MAG_N_W-1:0];
                r_low[k+1] <= r_low[k] << 1;
                r_q[k+1]   <= {r_q[k][QB-2:0], w_ge[k]};
                r_dm[k+1]  <= r_dm[k];
                r_neg[k+1] <= r_neg[k];
                r_ovf[k+1] <= r_ovf[k];
            end
        end
    end

    assign o_q   = r_q[QB];
    assign o_ovf = r_ovf[QB];
    assign o_neg = r_neg[QB];

endmodule

[sv/collinearity_projection.sv]
// Collinearity projection top level: pipeline control, final rounding and clamping.
//
// One word enters per cycle unless stalled; its result passes through 3 front-end
// stages for differences and rotation products, 4 stages for sign handling and
// the split 33x51 multiply, 35 stages that each resolve one quotient bit, and the
// output register. The whole pipeline advances together: when the output word is
// not taken, every stage holds and o_in_ready drops. Opcode 0 projects a ground
// point to the detector, opcode 1 intersects a detector ray with the plane at the
// given Z. Registers sit on the APB port at byte address 8*index, 64-bit data:
// rot_row_one..three, centre_x/y/z, focal_length, principal_point; write them only
// while no word is in flight.
module collinearity_projection (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_opcode,
    input  logic signed [cp_pkg::COORD_W-1:0]   i_in_a,
    input  logic signed [cp_pkg::COORD_W-1:0]   i_in_b,
    input  logic signed [cp_pkg::COORD_W-1:0]   i_in_z,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [cp_pkg::COORD_W-1:0]   o_out_a,
    output logic signed [cp_pkg::COORD_W-1:0]   o_out_b,
    output logic signed [cp_pkg::COORD_W-1:0]   o_out_z,
    output logic [1:0]                          o_status,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cp_pkg::ADDR_W-1:0]           paddr,
    input  logic [cp_pkg::DATA_W-1:0]           pwdata,
    output logic [cp_pkg::DATA_W-1:0]           prdata,
    output logic                                pready
);
    import cp_pkg::*;

    // {sat, value}
    function automatic logic [COORD_W:0] fin_calc(input logic [QB-1:0] q,
                                                  input logic ovf,
                                                  input logic neg,
                                                  input t_op op,
                                                  input logic signed [COORD_W-1:0] base);
        logic signed [FIN_W-1:0] sq;
        logic signed [FIN_W-1:0] sum;
        logic signed [FIN_W-1:0] hi;
        logic signed [FIN_W-1:0] lo;
        logic                    to_lo;
        hi    = $signed((FIN_W'(1) << (COORD_W-1)) - FIN_W'(1));
        lo    = -hi - FIN_W'(1);
        sq    = neg ? -$signed(FIN_W'(q)) : $signed(FIN_W'(q));
        sum   = (op == OP_PROJECT) ? FIN_W'(base) - sq : FIN_W'(base) + sq;
        to_lo = (op == OP_INTERSECT) ? neg : !neg;
        if (ovf) begin
            return {1'b1, to_lo ? lo[COORD_W-1:0] : hi[COORD_W-1:0]};
        end else if (sum > hi) begin
            return {1'b1, hi[COORD_W-1:0]};
        end else if (sum < lo) begin
            return {1'b1, lo[COORD_W-1:0]};
        end
        return {1'b0, sum[COORD_W-1:0]};
    endfunction

    t_cfg                       w_cfg;
    t_front                     w_front;
    logic signed [MAG_A_W-1:0]  w_ma;
    logic                       w_en;
    logic [QB-1:0]              w_q1;
    logic [QB-1:0]              w_q2;
    logic                       w_ovf1;
    logic                       w_ovf2;
    logic                       w_neg1;
    logic                       w_neg2;
    t_side                      w_side;
    logic signed [COORD_W-1:0]  w_base_a;
    logic signed [COORD_W-1:0]  w_base_b;
    logic [COORD_W:0]           w_fa;
    logic [COORD_W:0]           w_fb;

    logic                       r_vld  [0:TOT_LAT-1];
    t_side                      r_side [0:MD_LAT-1];
    logic [COORD_W-1:0]         r_out_a;
    logic [COORD_W-1:0]         r_out_b;
    logic [COORD_W-1:0]         r_out_z;
    t_status                    r_status;

    assign w_en       = !r_vld[TOT_LAT-1] || i_out_ready;
    assign o_in_ready = w_en;

    cp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    cp_front u_front (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_op    (i_opcode),
        .i_a     (i_in_a),
        .i_b     (i_in_b),
        .i_z     (i_in_z),
        .i_cfg   (w_cfg),
        .o_front (w_front)
    );

    assign w_ma = (w_front.op == OP_PROJECT) ? $signed(MAG_A_W'(w_cfg.foc)) : w_front.dz;

    cp_muldiv u_div_a (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (w_ma),
        .i_n   (w_front.n1),
        .i_d   (w_front.d),
        .o_q   (w_q1),
        .o_ovf (w_ovf1),
        .o_neg (w_neg1)
    );

    cp_muldiv u_div_b (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (w_ma),
        .i_n   (w_front.n2),
        .i_d   (w_front.d),
        .o_q   (w_q2),
        .o_ovf (w_ovf2),
        .o_neg (w_neg2)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TOT_LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= i_in_valid;
            for (int k = 1; k < TOT_LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // op, zero-denominator flag and Z ride alongside the dividers
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0].op   <= w_front.op;
            r_side[0].zero <= (w_front.d == '0);
            r_side[0].z    <= w_front.z;
            for (int k = 1; k < MD_LAT; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // principal point halves are signed
    assign w_side   = r_side[MD_LAT-1];
    assign w_base_a = (w_side.op == OP_PROJECT) ? COORD_W'($signed(w_cfg.pp[PP_W-1:0]))
                                                : w_cfg.cx;
    assign w_base_b = (w_side.op == OP_PROJECT) ? COORD_W'($signed(w_cfg.pp[2*PP_W-1:PP_W]))
                                                : w_cfg.cy;
    assign w_fa     = fin_calc(w_q1, w_ovf1, w_neg1, w_side.op, w_base_a);
    assign w_fb     = fin_calc(w_q2, w_ovf2, w_neg2, w_side.op, w_base_b);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_z <= (w_side.op == OP_INTERSECT) ? w_side.z : '0;
            if (w_side.zero) begin
                r_out_a  <= '0;
                r_out_b  <= '0;
                r_status <= ST_ZERO;
            end else begin
                r_out_a  <= w_fa[COORD_W-1:0];
                r_out_b  <= w_fb[COORD_W-1:0];
                r_status <= (w_fa[COORD_W] || w_fb[COORD_W]) ? ST_SAT : ST_OK;
            end
        end
    end

    assign o_out_valid = r_vld[TOT_LAT-1];
    assign o_out_a     = r_out_a;
    assign o_out_b     = r_out_b;
    assign o_out_z     = r_out_z;
    assign o_status    = r_status;

endmodule

[sv/cp_checker.sv]
// Port-level checks for the collinearity projection block, bound to the top level.
module cp_props (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 o_in_ready,
    input logic                                 o_out_valid,
    input logic                                 i_out_ready,
    input logic signed [cp_pkg::COORD_W-1:0]    o_out_a,
    input logic signed [cp_pkg::COORD_W-1:0]    o_out_b,
    input logic [1:0]                           o_status
);
    import cp_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output word valid right after reset");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_OK || o_status == ST_ZERO || o_status == ST_SAT))
        else $error("undefined status code");

    a_zero_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_ZERO) |-> (o_out_a == '0 && o_out_b == '0))
        else $error("zero denominator word carries nonzero coordinates");

    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
        (o_out_valid && $stable(o_out_a) && $stable(o_out_b) && $stable(o_status)))
        else $error("stalled output word changed");

endmodule

bind collinearity_projection cp_props u_cp_props (.*);
